// ===== hdl/key_line_token_scanner_macros.svh =====
`ifndef KEY_LINE_TOKEN_SCANNER_MACROS_SVH
`define KEY_LINE_TOKEN_SCANNER_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define KTSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define KTSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ktsc_pkg.sv =====
package ktsc_pkg;

  // field widths
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 13;
  localparam int KIND_W = 2;

  // defaults for the top-level parameters
  localparam int MAX_LINE_DEFAULT    = 4096;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

  // character classes seen by the scanner
  typedef enum logic [3:0] {
    CC_OTHER,
    CC_BLANK,
    CC_NEWLINE,
    CC_END,
    CC_COMMENT,
    CC_DASH,
    CC_PLUS_STAR,
    CC_GT,
    CC_BSLASH,
    CC_EQ,
    CC_COLON
  } char_class_t;

  // one classified request, as queued between front and back
  typedef struct packed {
    char_class_t cls;
    logic        start_scan;
    logic        accept_key;
    logic        accept_cont;
  } scan_item_t;

  // scanner phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_INDENT  = 4'd1,
    PH_MARK    = 4'd2,
    PH_MARK_GT = 4'd3,
    PH_BODY    = 4'd4,
    PH_ESC     = 4'd5,
    PH_SEP_END = 4'd6,
    PH_COLON   = 4'd7,
    PH_DASH    = 4'd8,
    PH_TAIL    = 4'd9
  } phase_t;

  // verdict kinds
  typedef enum logic [KIND_W-1:0] {
    TK_NONE = 2'd0,
    TK_KEY  = 2'd1,
    TK_CONT = 2'd2
  } token_kind_t;

endpackage

// ===== hdl/ktsc_in_if.sv =====
interface ktsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [ktsc_pkg::CHAR_W-1:0] char_code;
  logic                        end_of_input;
  logic                        start_scan;
  logic                        accept_key;
  logic                        accept_cont;

  modport source (
    output valid, char_code, end_of_input, start_scan, accept_key, accept_cont,
    input  ready
  );
  modport sink (
    input  valid, char_code, end_of_input, start_scan, accept_key, accept_cont,
    output ready
  );
endinterface

// ===== hdl/ktsc_out_if.sv =====
interface ktsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [ktsc_pkg::KIND_W-1:0] token_kind;
  logic [ktsc_pkg::LEN_W-1:0]  token_length;
  logic [ktsc_pkg::LEN_W-1:0]  indent_length;
  logic                        length_saturated;

  modport source (
    output valid, token_kind, token_length, indent_length, length_saturated,
    input  ready
  );
  modport sink (
    input  valid, token_kind, token_length, indent_length, length_saturated,
    output ready
  );
endinterface

// ===== hdl/ktsc_front.sv =====
module ktsc_front (
  ktsc_in_if.sink               chars,
  output logic                  push_valid,
  input  logic                  push_ready,
  output ktsc_pkg::scan_item_t  push_item
);

  ktsc_pkg::char_class_t cls;

  // sort the byte into the classes the scanner branches on
  always_comb begin
    if (chars.end_of_input) begin
      cls = ktsc_pkg::CC_END;
    end else begin
      unique case (chars.char_code)
        ktsc_pkg::CH_NUL:                    cls = ktsc_pkg::CC_END;
        ktsc_pkg::CH_NL:                     cls = ktsc_pkg::CC_NEWLINE;
        ktsc_pkg::CH_SPACE, ktsc_pkg::CH_TAB: cls = ktsc_pkg::CC_BLANK;
        ktsc_pkg::CH_SLASH, ktsc_pkg::CH_HASH: cls = ktsc_pkg::CC_COMMENT;
        ktsc_pkg::CH_MINUS:                  cls = ktsc_pkg::CC_DASH;
        ktsc_pkg::CH_PLUS, ktsc_pkg::CH_STAR: cls = ktsc_pkg::CC_PLUS_STAR;
        ktsc_pkg::CH_GT:                     cls = ktsc_pkg::CC_GT;
        ktsc_pkg::CH_BSLASH:                 cls = ktsc_pkg::CC_BSLASH;
        ktsc_pkg::CH_EQ:                     cls = ktsc_pkg::CC_EQ;
        ktsc_pkg::CH_COLON:                  cls = ktsc_pkg::CC_COLON;
        default:                             cls = ktsc_pkg::CC_OTHER;
      endcase
    end
  end

  // hand the classified request to the queue
  assign push_item.cls         = cls;
  assign push_item.start_scan  = chars.start_scan;
  assign push_item.accept_key  = chars.accept_key;
  assign push_item.accept_cont = chars.accept_cont;
  assign push_valid            = chars.valid;
  assign chars.ready           = push_ready;

endmodule

// ===== hdl/ktsc_queue.sv =====
module ktsc_queue #(
  parameter int DEPTH = ktsc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  ktsc_pkg::scan_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output ktsc_pkg::scan_item_t pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [NW-1:0] FULL = NW'(DEPTH);

  ktsc_pkg::scan_item_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + NW'(push) - NW'(pop);
    end
  end

endmodule

// ===== hdl/ktsc_back.sv =====
`include "key_line_token_scanner_macros.svh"

module ktsc_back #(
  parameter int MAX_LINE = ktsc_pkg::MAX_LINE_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  ktsc_pkg::scan_item_t item,
  ktsc_out_if.source           verdict
);

  localparam int CW = $clog2(MAX_LINE + 1);
  localparam int XW = (CW > ktsc_pkg::LEN_W) ? CW : ktsc_pkg::LEN_W;
  localparam logic [CW-1:0] MAXC = CW'(MAX_LINE);

  // scanner state
  ktsc_pkg::phase_t phase, phase_next;
  logic             indent_seen, indent_seen_next;
  logic             content_seen, content_seen_next;
  logic             marker_was_dash, marker_was_dash_next;
  logic             key_wanted, key_wanted_next;
  logic             cont_wanted, cont_wanted_next;
  logic [CW-1:0]    position_count, position_count_next;
  logic [CW-1:0]    key_end, key_end_next;
  logic [CW-1:0]    indent_count, indent_count_next;
  logic             saturated_flag, saturated_flag_next;

  // output register
  logic                        out_valid;
  ktsc_pkg::token_kind_t       out_kind;
  logic [ktsc_pkg::LEN_W-1:0]  out_len;
  logic [ktsc_pkg::LEN_W-1:0]  out_ind;
  logic                        out_sat;

  // step working signals
  logic                  pop;
  logic                  blank, eol, wse;
  logic [CW-1:0]         pos_base, ind_base, pos_inc, ind_inc;
  ktsc_pkg::phase_t      cur;
  logic                  run, to_body, to_end, sep_hit, to_tail;
  logic                  emit;
  ktsc_pkg::token_kind_t kind;
  logic [CW-1:0]         len_c;
  logic [XW-1:0]         len_x, ind_x;

  assign pop        = item_valid && item_ready;
  assign item_ready = !out_valid || verdict.ready;

  assign blank = (item.cls == ktsc_pkg::CC_BLANK);
  assign eol   = (item.cls == ktsc_pkg::CC_NEWLINE) || (item.cls == ktsc_pkg::CC_END);
  assign wse   = blank || eol;

  // a start request begins from cleared counts
  assign pos_base = item.start_scan ? '0 : position_count;
  assign ind_base = item.start_scan ? '0 : indent_count;
  assign pos_inc  = (pos_base < MAXC) ? pos_base + CW'(1) : pos_base;
  assign ind_inc  = (ind_base < MAXC) ? ind_base + CW'(1) : ind_base;

  // one character per step: phase handling, key body, end of key, tail
  always_comb begin
    phase_next           = phase;
    indent_seen_next     = indent_seen;
    content_seen_next    = content_seen;
    marker_was_dash_next = marker_was_dash;
    key_wanted_next      = key_wanted;
    cont_wanted_next     = cont_wanted;
    position_count_next  = position_count;
    key_end_next         = key_end;
    indent_count_next    = indent_count;
    saturated_flag_next  = saturated_flag;
    cur     = phase;
    run     = 1'b0;
    to_body = 1'b0;
    to_end  = 1'b0;
    sep_hit = 1'b0;
    to_tail = 1'b0;
    emit    = 1'b0;
    kind    = ktsc_pkg::TK_NONE;
    len_c   = '0;

    if (pop) begin
      // start of a scan: clear state, latch what is wanted
      if (item.start_scan) begin
        indent_seen_next     = 1'b0;
        content_seen_next    = 1'b0;
        marker_was_dash_next = 1'b0;
        position_count_next  = '0;
        key_end_next         = '0;
        indent_count_next    = '0;
        saturated_flag_next  = 1'b0;
        key_wanted_next      = item.accept_key;
        cont_wanted_next     = item.accept_cont;
        if (!item.accept_key && !item.accept_cont) begin
          emit = 1'b1;
        end else begin
          cur = ktsc_pkg::PH_INDENT;
          run = 1'b1;
        end
      end else if (phase != ktsc_pkg::PH_IDLE) begin
        run = 1'b1;
      end
    end

    // current phase
    if (run) begin
      phase_next = cur;
      unique case (cur)
        ktsc_pkg::PH_INDENT: begin
          if (blank) begin
            indent_count_next   = ind_inc;
            saturated_flag_next = saturated_flag_next | (ind_inc == MAXC);
            indent_seen_next    = 1'b1;
          end else if (eol || item.cls == ktsc_pkg::CC_COMMENT) begin
            emit = 1'b1;
          end else begin
            key_end_next = '0;
            if (item.cls == ktsc_pkg::CC_DASH || item.cls == ktsc_pkg::CC_PLUS_STAR) begin
              marker_was_dash_next = (item.cls == ktsc_pkg::CC_DASH);
              position_count_next  = pos_inc;
              saturated_flag_next  = saturated_flag_next | (pos_inc == MAXC);
              phase_next           = ktsc_pkg::PH_MARK;
            end else begin
              to_body = 1'b1;
            end
          end
        end
        ktsc_pkg::PH_MARK: begin
          if (blank) begin
            emit = 1'b1;
          end else if (marker_was_dash && item.cls == ktsc_pkg::CC_GT) begin
            position_count_next = pos_inc;
            saturated_flag_next = saturated_flag_next | (pos_inc == MAXC);
            phase_next          = ktsc_pkg::PH_MARK_GT;
          end else begin
            key_end_next = pos_base;
            to_body      = 1'b1;
          end
        end
        ktsc_pkg::PH_MARK_GT: begin
          // lone arrow after a dash marker counts as a one-character key
          if (wse) begin
            emit = 1'b1;
            if (key_wanted_next) begin
              kind  = ktsc_pkg::TK_KEY;
              len_c = CW'(1);
            end
          end else begin
            key_end_next = pos_base;
            to_body      = 1'b1;
          end
        end
        ktsc_pkg::PH_BODY: begin
          to_body = 1'b1;
        end
        ktsc_pkg::PH_ESC: begin
          // escaped character is content; a bare backslash at end of line too
          if (!eol) begin
            position_count_next = pos_inc;
            saturated_flag_next = saturated_flag_next | (pos_inc == MAXC);
            key_end_next        = pos_inc;
            phase_next          = ktsc_pkg::PH_BODY;
          end else begin
            key_end_next = pos_base;
            to_body      = 1'b1;
          end
        end
        ktsc_pkg::PH_COLON, ktsc_pkg::PH_DASH: begin
          if ((cur == ktsc_pkg::PH_COLON && item.cls == ktsc_pkg::CC_EQ) ||
              (cur == ktsc_pkg::PH_DASH && item.cls == ktsc_pkg::CC_GT)) begin
            position_count_next = pos_inc;
            saturated_flag_next = saturated_flag_next | (pos_inc == MAXC);
            phase_next          = ktsc_pkg::PH_SEP_END;
          end else if (cur == ktsc_pkg::PH_COLON && wse) begin
            to_end  = 1'b1;
            sep_hit = 1'b1;
          end else begin
            content_seen_next = 1'b1;
            key_end_next      = pos_base;
            to_body           = 1'b1;
          end
        end
        ktsc_pkg::PH_SEP_END: begin
          if (wse) begin
            to_end  = 1'b1;
            sep_hit = 1'b1;
          end else begin
            content_seen_next = 1'b1;
            key_end_next      = pos_base;
            to_body           = 1'b1;
          end
        end
        ktsc_pkg::PH_TAIL: begin
          to_tail = 1'b1;
        end
        default: begin
          phase_next = ktsc_pkg::PH_IDLE;
        end
      endcase
    end

    // key body character
    if (to_body) begin
      phase_next = ktsc_pkg::PH_BODY;
      if (eol) begin
        to_end = 1'b1;
      end else begin
        position_count_next = pos_inc;
        saturated_flag_next = saturated_flag_next | (pos_inc == MAXC);
        priority case (item.cls)
          ktsc_pkg::CC_BSLASH: begin
            content_seen_next = 1'b1;
            phase_next        = ktsc_pkg::PH_ESC;
          end
          ktsc_pkg::CC_EQ:    phase_next = ktsc_pkg::PH_SEP_END;
          ktsc_pkg::CC_COLON: phase_next = ktsc_pkg::PH_COLON;
          ktsc_pkg::CC_DASH:  phase_next = ktsc_pkg::PH_DASH;
          ktsc_pkg::CC_BLANK: ;
          default: begin
            content_seen_next = 1'b1;
            key_end_next      = pos_inc;
          end
        endcase
      end
    end

    // key content ended at a separator or end of line
    if (to_end) begin
      if (sep_hit && content_seen_next) begin
        emit = 1'b1;
        if (key_wanted_next) begin
          kind  = ktsc_pkg::TK_KEY;
          len_c = key_end_next;
        end
      end else if (cont_wanted_next && indent_seen_next) begin
        to_tail = 1'b1;
      end else begin
        emit = 1'b1;
      end
    end

    // continuation line runs through the newline
    if (to_tail) begin
      phase_next = ktsc_pkg::PH_TAIL;
      if (eol) begin
        if (item.cls == ktsc_pkg::CC_NEWLINE) begin
          position_count_next = pos_inc;
          saturated_flag_next = saturated_flag_next | (pos_inc == MAXC);
        end
        emit  = 1'b1;
        kind  = ktsc_pkg::TK_CONT;
        len_c = position_count_next;
      end else begin
        position_count_next = pos_inc;
        saturated_flag_next = saturated_flag_next | (pos_inc == MAXC);
      end
    end

    if (emit) begin
      phase_next = ktsc_pkg::PH_IDLE;
    end
  end

  assign len_x = XW'(len_c);
  assign ind_x = XW'(indent_count_next);

  // scanner state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ktsc_pkg::PH_IDLE;
      indent_seen     <= 1'b0;
      content_seen    <= 1'b0;
      marker_was_dash <= 1'b0;
      key_wanted      <= 1'b0;
      cont_wanted     <= 1'b0;
      position_count  <= '0;
      key_end         <= '0;
      indent_count    <= '0;
      saturated_flag  <= 1'b0;
    end else begin
      phase           <= phase_next;
      indent_seen     <= indent_seen_next;
      content_seen    <= content_seen_next;
      marker_was_dash <= marker_was_dash_next;
      key_wanted      <= key_wanted_next;
      cont_wanted     <= cont_wanted_next;
      position_count  <= position_count_next;
      key_end         <= key_end_next;
      indent_count    <= indent_count_next;
      saturated_flag  <= saturated_flag_next;
    end
  end

  // verdict holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind <= kind;
      out_len  <= len_x[ktsc_pkg::LEN_W-1:0];
      out_ind  <= ind_x[ktsc_pkg::LEN_W-1:0];
      out_sat  <= saturated_flag_next;
    end
  end

  assign verdict.valid            = out_valid;
  assign verdict.token_kind       = out_kind;
  assign verdict.token_length     = out_len;
  assign verdict.indent_length    = out_ind;
  assign verdict.length_saturated = out_sat;

  // checks
  `KTSC_ASSERT_NOW(a_idle_silent,
                   pop && !item.start_scan && phase == ktsc_pkg::PH_IDLE,
                   !emit, "verdict from an idle scanner")
  `KTSC_ASSERT_NOW(a_none_zero_len, emit && kind == ktsc_pkg::TK_NONE,
                   len_c == '0, "no-token verdict with a length")
  `KTSC_ASSERT_NOW(a_cont_allowed, emit && kind == ktsc_pkg::TK_CONT,
                   cont_wanted_next && indent_seen_next, "continuation not allowed here")
  `KTSC_ASSERT_NOW(a_unsat_bounds, emit && !saturated_flag_next,
                   len_c < MAXC && indent_count_next < MAXC,
                   "count at limit without saturation flag")
  `KTSC_ASSERT_NEXT(a_nothing_wanted,
                    pop && item.start_scan && !item.accept_key && !item.accept_cont,
                    out_valid, "nothing-wanted scan gave no verdict")

endmodule

// ===== hdl/key_line_token_scanner.sv =====
// Scans one line of a key/value text format, one character request per clock
// while the queue has room, and gives at most one verdict per scan (no token,
// key, or continuation line) with token and indent lengths. A new character is
// taken every cycle while the two-entry queue has room; the scanner state
// machine in the back stage retires one character per cycle while its output
// is not held, so the sustained rate is one character per cycle. A verdict
// enters the output register once its deciding character has left the queue
// and been scanned. While a verdict waits in the output register the scanner
// holds, the queue fills and the input then stalls until the verdict is taken.
// Counts stop at MAX_LINE and set length_saturated; lengths are reported in 13 bits.
module key_line_token_scanner #(
  parameter int MAX_LINE    = ktsc_pkg::MAX_LINE_DEFAULT,
  parameter int QUEUE_DEPTH = ktsc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  ktsc_in_if.sink     chars,
  ktsc_out_if.source  verdict
);

  logic                 push_valid;
  logic                 push_ready;
  ktsc_pkg::scan_item_t push_item;
  logic                 pop_valid;
  logic                 pop_ready;
  ktsc_pkg::scan_item_t pop_item;

  // classify incoming characters
  ktsc_front u_front (
    .chars      (chars),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decouple front and scanner
  ktsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // scanner and verdict register
  ktsc_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (pop_valid),
    .item_ready (pop_ready),
    .item       (pop_item),
    .verdict    (verdict)
  );

endmodule

// ===== test/key_line_token_scanner_test.sv =====
`timescale 1ns / 1ps

module key_line_token_scanner_test;

  localparam int LINE_LIMIT  = ktsc_pkg::MAX_LINE_DEFAULT;
  localparam int LW          = ktsc_pkg::LEN_W;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 2000;
  localparam int SETTLE      = 8;

  // one expected verdict of a scan
  typedef struct packed {
    ktsc_pkg::token_kind_t kind;
    logic [LW-1:0]         tok_len;
    logic [LW-1:0]         ind_len;
    logic                  sat;
  } verdict_t;

  // how a generated line is closed
  typedef enum logic [1:0] {END_NONE, END_NL, END_NUL, END_EOI} line_end_t;

  logic clk;
  logic rst;

  ktsc_in_if  chars ();
  ktsc_out_if verdict ();

  key_line_token_scanner #(
    .MAX_LINE (LINE_LIMIT)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .verdict (verdict)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // scanner state as predicted
  ktsc_pkg::phase_t scan_ph;
  logic             ind_seen;
  logic             text_seen;
  logic             dash_mark;
  logic             key_ok;
  logic             cont_ok;
  logic [LW-1:0]    col_cnt;
  logic [LW-1:0]    key_stop;
  logic [LW-1:0]    lead_cnt;
  logic             hit_max;

  verdict_t         verdict_q[$];
  logic [8:0]       line_buf[$];

  int               send_idle_pct;
  int               recv_idle_pct;
  logic             hold_on = 1'b0;
  event             hold_ev;

  int               err_cnt;
  int               chars_sent;
  int               live_items;
  int               scans_sent;
  int               kind_tally [3];
  int               sat_tally;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_scan();
    scan_ph   = ktsc_pkg::PH_IDLE;
    ind_seen  = 1'b0;
    text_seen = 1'b0;
    dash_mark = 1'b0;
    key_ok    = 1'b0;
    cont_ok   = 1'b0;
    col_cnt   = '0;
    key_stop  = '0;
    lead_cnt  = '0;
    hit_max   = 1'b0;
  endfunction

  // counts stop at the line limit and raise the saturation flag there
  function automatic logic [LW-1:0] count_up(input logic [LW-1:0] n);
    if (n < LINE_LIMIT) n = n + 1'b1;
    if (n >= LINE_LIMIT) hit_max = 1'b1;
    return n;
  endfunction

  function automatic verdict_t close_scan(input ktsc_pkg::token_kind_t kind,
                                          input logic [LW-1:0] len);
    verdict_t v;
    v.kind    = kind;
    v.tok_len = len;
    v.ind_len = lead_cnt;
    v.sat     = hit_max;
    scan_ph   = ktsc_pkg::PH_IDLE;
    return v;
  endfunction

  // a key found is only reported when a key was asked for
  function automatic verdict_t key_verdict(input logic [LW-1:0] len);
    if (key_ok) return close_scan(ktsc_pkg::TK_KEY, len);
    return close_scan(ktsc_pkg::TK_NONE, '0);
  endfunction

  // advance the scan by one character; returns 1 when the verdict is decided
  function automatic bit scan_char(input logic [7:0] code, input logic eoi,
                                   input logic start, input logic key_on,
                                   input logic cont_on, output verdict_t v);
    logic [7:0] c;
    logic       eol;
    logic       blank;
    logic       wse;
    logic       sep_hit;
    logic       key_done;
    logic       again;
    bit         got;
    c     = eoi ? ktsc_pkg::CH_NUL : code;
    eol   = eoi || c == ktsc_pkg::CH_NL || c == ktsc_pkg::CH_NUL;
    blank = c == ktsc_pkg::CH_SPACE || c == ktsc_pkg::CH_TAB;
    wse   = blank || eol;
    v     = '0;
    got   = 1'b0;
    again = 1'b1;
    if (start) begin
      clear_scan();
      key_ok  = key_on;
      cont_ok = cont_on;
      if (!key_on && !cont_on) begin
        v     = close_scan(ktsc_pkg::TK_NONE, '0);
        got   = 1'b1;
        again = 1'b0;
      end else begin
        scan_ph = ktsc_pkg::PH_INDENT;
      end
    end else if (scan_ph == ktsc_pkg::PH_IDLE) begin
      again = 1'b0;
    end

    while (again) begin
      again    = 1'b0;
      sep_hit  = 1'b0;
      key_done = 1'b0;
      case (scan_ph)
        ktsc_pkg::PH_INDENT: begin
          if (blank) begin
            lead_cnt = count_up(lead_cnt);
            ind_seen = 1'b1;
          end else if (eol || c == ktsc_pkg::CH_SLASH || c == ktsc_pkg::CH_HASH) begin
            v   = close_scan(ktsc_pkg::TK_NONE, '0);
            got = 1'b1;
          end else if (c == ktsc_pkg::CH_MINUS || c == ktsc_pkg::CH_PLUS ||
                       c == ktsc_pkg::CH_STAR) begin
            key_stop  = '0;
            dash_mark = c == ktsc_pkg::CH_MINUS;
            col_cnt   = count_up('0);
            scan_ph   = ktsc_pkg::PH_MARK;
          end else begin
            key_stop = '0;
            scan_ph  = ktsc_pkg::PH_BODY;
            again    = 1'b1;
          end
        end
        ktsc_pkg::PH_MARK: begin
          if (blank) begin
            v   = close_scan(ktsc_pkg::TK_NONE, '0);
            got = 1'b1;
          end else if (dash_mark && c == ktsc_pkg::CH_GT) begin
            col_cnt = count_up(col_cnt);
            scan_ph = ktsc_pkg::PH_MARK_GT;
          end else begin
            key_stop = col_cnt;
            scan_ph  = ktsc_pkg::PH_BODY;
            again    = 1'b1;
          end
        end
        // a lone arrow after the dash is a key of one character
        ktsc_pkg::PH_MARK_GT: begin
          if (wse) begin
            v   = key_verdict(LW'(1));
            got = 1'b1;
          end else begin
            key_stop = col_cnt;
            scan_ph  = ktsc_pkg::PH_BODY;
            again    = 1'b1;
          end
        end
        ktsc_pkg::PH_BODY: begin
          if (eol) begin
            key_done = 1'b1;
          end else begin
            col_cnt = count_up(col_cnt);
            if (c == ktsc_pkg::CH_BSLASH) begin
              text_seen = 1'b1;
              scan_ph   = ktsc_pkg::PH_ESC;
            end else if (c == ktsc_pkg::CH_EQ) begin
              scan_ph = ktsc_pkg::PH_SEP_END;
            end else if (c == ktsc_pkg::CH_COLON) begin
              scan_ph = ktsc_pkg::PH_COLON;
            end else if (c == ktsc_pkg::CH_MINUS) begin
              scan_ph = ktsc_pkg::PH_DASH;
            end else if (!blank) begin
              text_seen = 1'b1;
              key_stop  = col_cnt;
            end
          end
        end
        // escaped character, or the backslash alone at end of line
        ktsc_pkg::PH_ESC: begin
          if (!eol) col_cnt = count_up(col_cnt);
          key_stop = col_cnt;
          scan_ph  = ktsc_pkg::PH_BODY;
          again    = eol;
        end
        ktsc_pkg::PH_COLON, ktsc_pkg::PH_DASH: begin
          if (c == ((scan_ph == ktsc_pkg::PH_COLON) ? ktsc_pkg::CH_EQ : ktsc_pkg::CH_GT)) begin
            col_cnt = count_up(col_cnt);
            scan_ph = ktsc_pkg::PH_SEP_END;
          end else if (scan_ph == ktsc_pkg::PH_COLON && wse) begin
            sep_hit  = 1'b1;
            key_done = 1'b1;
          end else begin
            text_seen = 1'b1;
            key_stop  = col_cnt;
            scan_ph   = ktsc_pkg::PH_BODY;
            again     = 1'b1;
          end
        end
        ktsc_pkg::PH_SEP_END: begin
          if (wse) begin
            sep_hit  = 1'b1;
            key_done = 1'b1;
          end else begin
            text_seen = 1'b1;
            key_stop  = col_cnt;
            scan_ph   = ktsc_pkg::PH_BODY;
            again     = 1'b1;
          end
        end
        // continuation runs through the newline
        ktsc_pkg::PH_TAIL: begin
          if (eol) begin
            if (c == ktsc_pkg::CH_NL) col_cnt = count_up(col_cnt);
            v   = close_scan(ktsc_pkg::TK_CONT, col_cnt);
            got = 1'b1;
          end else begin
            col_cnt = count_up(col_cnt);
          end
        end
        default: scan_ph = ktsc_pkg::PH_IDLE;
      endcase

      // key content over: separator or end of line
      if (key_done) begin
        if (sep_hit && text_seen) begin
          v   = key_verdict(key_stop);
          got = 1'b1;
        end else if (cont_ok && ind_seen) begin
          scan_ph = ktsc_pkg::PH_TAIL;
          again   = 1'b1;
        end else begin
          v   = close_scan(ktsc_pkg::TK_NONE, '0);
          got = 1'b1;
        end
      end
    end
    return got;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 100) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    if (!rst && verdict.valid && verdict.ready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("verdict kind %0d length %0d with none expected",
                                  verdict.token_kind, verdict.token_length));
      end else begin
        want = verdict_q.pop_front();
        if (verdict.token_kind !== want.kind)
          report_mismatch($sformatf("token_kind %0d, expected %0d",
                                    verdict.token_kind, want.kind));
        if (verdict.token_length !== want.tok_len)
          report_mismatch($sformatf("token_length %0d, expected %0d",
                                    verdict.token_length, want.tok_len));
        if (verdict.indent_length !== want.ind_len)
          report_mismatch($sformatf("indent_length %0d, expected %0d",
                                    verdict.indent_length, want.ind_len));
        if (verdict.length_saturated !== want.sat)
          report_mismatch($sformatf("length_saturated %0b, expected %0b",
                                    verdict.length_saturated, want.sat));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver side
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || hold_on) begin
      verdict.ready <= 1'b0;
    end else begin
      verdict.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long output hold-off, counted here
  always begin
    @(hold_ev);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one character request and wait until it is taken
  task automatic send_char(input logic [7:0] code, input logic eoi, input logic start,
                           input logic key_on, input logic cont_on);
    verdict_t v;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      chars.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    chars.valid        <= 1'b1;
    chars.char_code    <= code;
    chars.end_of_input <= eoi;
    chars.start_scan   <= start;
    chars.accept_key   <= key_on;
    chars.accept_cont  <= cont_on;
    do @(posedge clk); while (!chars.ready);
    chars_sent++;
    if (start || scan_ph != ktsc_pkg::PH_IDLE) live_items++;
    if (scan_char(code, eoi, start, key_on, cont_on, v)) begin
      verdict_q.push_back(v);
      kind_tally[v.kind]++;
      if (v.sat) sat_tally++;
    end
  endtask

  task automatic put_byte(input logic [7:0] b);
    line_buf.push_back({1'b0, b});
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back({1'b0, s[i]});
  endtask

  task automatic put_end(input line_end_t e);
    case (e)
      END_NL:  line_buf.push_back({1'b0, ktsc_pkg::CH_NL});
      END_NUL: line_buf.push_back({1'b0, ktsc_pkg::CH_NUL});
      END_EOI: line_buf.push_back({1'b1, 8'($urandom_range(255))});
      default: ;
    endcase
  endtask

  // want bits only count on the start request, so they are random elsewhere
  task automatic send_line(input logic key_on, input logic cont_on);
    for (int i = 0; i < line_buf.size(); i++) begin
      send_char(line_buf[i][7:0], line_buf[i][8], i == 0,
                (i == 0) ? key_on : 1'($urandom_range(1)),
                (i == 0) ? cont_on : 1'($urandom_range(1)));
    end
    line_buf.delete();
    scans_sent++;
  endtask

  task automatic scan_text(input string s, input line_end_t e, input logic key_on,
                           input logic cont_on);
    put_text(s);
    put_end(e);
    send_line(key_on, cont_on);
  endtask

  // stop offering and let every outstanding verdict come out
  task automatic await_verdicts();
    int waited;
    waited = 0;
    chars.valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (verdict_q.size() != 0 && waited < DRAIN_LIMIT);
    while (verdict_q.size() != 0) begin
      report_mismatch($sformatf("verdict kind %0d never arrived", verdict_q[0].kind));
      void'(verdict_q.pop_front());
    end
  endtask

  task automatic set_idling(input int snd, input int rcv);
    send_idle_pct = snd;
    recv_idle_pct <= rcv;
  endtask

  // ---------------------------------------------------------------------------
  // random line generation
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_blank();
    return $urandom_range(1) ? ktsc_pkg::CH_TAB : ktsc_pkg::CH_SPACE;
  endfunction

  function automatic logic [7:0] pick_body_char();
    case ($urandom_range(11))
      0:       return ktsc_pkg::CH_BSLASH;
      1:       return ktsc_pkg::CH_MINUS;
      2:       return ktsc_pkg::CH_COLON;
      3:       return ktsc_pkg::CH_EQ;
      4:       return pick_blank();
      5:       return ktsc_pkg::CH_GT;
      6:       return 8'($urandom_range(8'hFF, 8'h80));
      default: return 8'($urandom_range(8'h7E, 8'h21));
    endcase
  endfunction

  // mostly key/value shaped lines with random content, some plain noise
  task automatic build_random_line(output logic key_on, output logic cont_on);
    int pick;
    pick = $urandom_range(9);
    key_on  = !(pick == 0 || (pick >= 3 && pick <= 4));
    cont_on = !(pick <= 2);
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(12, 1)) put_byte(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(2) != 0) repeat ($urandom_range(5, 1)) put_byte(pick_blank());
      case ($urandom_range(11))
        0:       put_byte(ktsc_pkg::CH_MINUS);
        1:       put_byte(ktsc_pkg::CH_PLUS);
        2:       put_byte(ktsc_pkg::CH_STAR);
        3:       put_text("->");
        4:       put_byte(ktsc_pkg::CH_HASH);
        5:       put_byte(ktsc_pkg::CH_SLASH);
        default: ;
      endcase
      if ($urandom_range(3) == 0) put_byte(pick_blank());
      repeat ($urandom_range(6)) put_byte(pick_body_char());
      case ($urandom_range(5))
        0:       put_text("=");
        1:       put_text(":");
        2:       put_text(":=");
        3:       put_text("->");
        default: ;
      endcase
      if ($urandom_range(2) != 0) put_byte(pick_blank());
      repeat ($urandom_range(5)) put_byte(pick_body_char());
    end
    // an open line is abandoned by the next start
    pick = $urandom_range(19);
    if (pick == 0) put_end(END_NONE);
    else if (pick <= 4) put_end(END_NUL);
    else if (pick <= 8) put_end(END_EOI);
    else put_end(END_NL);
    if (line_buf.size() == 0) put_end(END_NL);
  endtask

  task automatic send_random_line();
    logic key_on;
    logic cont_on;
    build_random_line(key_on, cont_on);
    send_line(key_on, cont_on);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    // nothing wanted gives an immediate verdict
    scan_text("a = b", END_NL, 1'b0, 1'b0);
    // empty lines with each kind of end
    scan_text("", END_NL, 1'b1, 1'b1);
    scan_text("", END_NUL, 1'b1, 1'b1);
    scan_text("", END_EOI, 1'b1, 1'b1);
    // comments and list markers
    scan_text("# note", END_NL, 1'b1, 1'b1);
    scan_text("  // note", END_NL, 1'b1, 1'b1);
    scan_text("- item", END_NL, 1'b1, 1'b1);
    scan_text("+\tx", END_NUL, 1'b1, 1'b1);
    scan_text("* y", END_EOI, 1'b1, 1'b1);
    // each separator, trailing blanks dropped from the key
    scan_text("key = v", END_NL, 1'b1, 1'b0);
    scan_text("\tname: v", END_NL, 1'b1, 1'b1);
    scan_text("k := v", END_NUL, 1'b1, 1'b1);
    scan_text("a -> b", END_EOI, 1'b1, 1'b1);
    scan_text("ab=", END_EOI, 1'b1, 1'b1);
    scan_text("key   :", END_NL, 1'b1, 1'b1);
    // escapes, and a backslash alone at end of line
    scan_text("a\\= b = c", END_NL, 1'b1, 1'b1);
    scan_text("ab\\", END_EOI, 1'b1, 1'b1);
    // key found but not wanted
    scan_text("key = v", END_NL, 1'b0, 1'b1);
    // separator with no content ahead of it
    scan_text("  = x", END_NL, 1'b1, 1'b1);
    // lone dash arrow
    scan_text("->", END_NL, 1'b1, 1'b0);
    scan_text("  -> x", END_NL, 1'b0, 1'b1);
    scan_text("->x = 1", END_NL, 1'b1, 1'b1);
    scan_text("-x: y", END_NL, 1'b1, 1'b1);
    // continuation lines with each kind of end
    scan_text("  more text", END_NL, 1'b0, 1'b1);
    scan_text("\tmore", END_NUL, 1'b1, 1'b1);
    scan_text(" more", END_EOI, 1'b0, 1'b1);
    // restart in the middle of a scan
    scan_text("  abc", END_NONE, 1'b1, 1'b1);
    scan_text("x=1", END_NL, 1'b1, 1'b1);
    // extreme byte values
    put_byte(8'hFF);
    put_byte(8'h80);
    put_text("= ");
    put_byte(8'h01);
    put_end(END_NL);
    send_line(1'b1, 1'b1);
  endtask

  // counts running into the line limit
  task automatic test_saturation();
    repeat (LINE_LIMIT + 4) put_byte(ktsc_pkg::CH_SPACE);
    put_end(END_NL);
    send_line(1'b1, 1'b0);
    put_text("k");
    repeat (LINE_LIMIT + 4) put_text("x");
    scan_text("= 1", END_NL, 1'b1, 1'b0);
    put_byte(ktsc_pkg::CH_TAB);
    repeat (LINE_LIMIT + 4) put_text("y");
    scan_text("", END_NL, 1'b0, 1'b1);
  endtask

  // output held off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    -> hold_ev;
    repeat (20) scan_text("k: v", END_NL, 1'b1, 1'b1);
    repeat (20) send_random_line();
  endtask

  // sender stops until the scanner has handed out everything
  task automatic test_pause();
    repeat (10) send_random_line();
    await_verdicts();
    repeat (10) send_random_line();
  endtask

  task automatic test_random(input int n_items);
    int goal;
    goal = live_items + n_items;
    while (live_items < goal) begin
      // stray requests with no start
      if ($urandom_range(19) == 0) begin
        repeat ($urandom_range(3, 1))
          send_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0,
                    1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      send_random_line();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst                <= 1'b1;
    chars.valid        <= 1'b0;
    chars.char_code    <= '0;
    chars.end_of_input <= 1'b0;
    chars.start_scan   <= 1'b0;
    chars.accept_key   <= 1'b0;
    chars.accept_cont  <= 1'b0;
    err_cnt    = 0;
    chars_sent = 0;
    live_items = 0;
    scans_sent = 0;
    sat_tally  = 0;
    kind_tally = '{0, 0, 0};
    clear_scan();
    set_idling(24, 66);
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(400);
    set_idling(66, 24);
    test_backpressure();
    test_pause();
    test_random(400);
    set_idling(0, 0);
    test_saturation();
    test_random(450);

    await_verdicts();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d scans, %0d character requests (%0d inside a scan)",
             scans_sent, chars_sent, live_items);
    $display("verdicts: %0d no token, %0d key, %0d continuation, %0d saturated",
             kind_tally[ktsc_pkg::TK_NONE], kind_tally[ktsc_pkg::TK_KEY],
             kind_tally[ktsc_pkg::TK_CONT], sat_tally);
    if (err_cnt == 0) begin
      $display("key_line_token_scanner_test OK");
    end else begin
      $display("key_line_token_scanner_test NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("timeout: the scanner stopped making progress");
    $display("key_line_token_scanner_test NOT OK");
    $finish;
  end

endmodule
